[hdl/bdpc_pkg.sv]
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int SW_W     = 3;
    localparam int EV_W     = 3;
    localparam int ST_W     = 3;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 2;
    localparam int TIMER_W  = CFG_W + 1;

    // Default switch count
    localparam int NUM_SWITCHES_DEF = 7;

    // Register reset values
    localparam logic [CFG_W-1:0] BOUNCE_RST = 14'd20;
    localparam logic [CFG_W-1:0] SHORT_RST  = 14'd1000;
    localparam logic [CFG_W-1:0] LONG_RST   = 14'd2000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 2'd2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_EVAL  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Machine states
    localparam logic [ST_W-1:0] ST_IDLE          = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESSED       = 3'd1;
    localparam logic [ST_W-1:0] ST_BOUNCE        = 3'd2;
    localparam logic [ST_W-1:0] ST_CONFIRMED     = 3'd3;
    localparam logic [ST_W-1:0] ST_WAIT_REL      = 3'd4;
    localparam logic [ST_W-1:0] ST_WAIT_REL_LONG = 3'd5;
    localparam logic [ST_W-1:0] ST_REL_BOUNCE    = 3'd6;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE          = 3'd0;
    localparam logic [EV_W-1:0] EV_JUST_PRESSED  = 3'd1;
    localparam logic [EV_W-1:0] EV_SHORT         = 3'd2;
    localparam logic [EV_W-1:0] EV_LONG          = 3'd3;
    localparam logic [EV_W-1:0] EV_JUST_RELEASED = 3'd4;

    // Input word
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [SW_W-1:0] sw_index;
        logic            pressed;
    } t_in_item;

    // Result word
    typedef struct packed {
        logic [EV_W-1:0] event_code;
        logic [ST_W-1:0] machine_state;
    } t_out_item;

    // Timer bank control
    typedef struct packed {
        logic tick;
        logic clr;
    } t_timer_cmd;

endpackage

[hdl/button_debounce_press_classifier_top.sv]
// An accepted word is held in the input register; its result then goes to the result
// register, which drives the output. Throughput: one word per cycle while the output is
// not stalled, set by the single-pass update of the addressed switch between the two registers.
// Reset (i_rst_n low, synchronous): all switches idle, timers zero, events none,
// registers back to 20 / 1000 / 2000, both pipeline registers empty.
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top
// Debounces several push buttons and classifies short and long presses.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top
    import bdpc_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

    logic [CFG_W-1:0]   r_bounce;
    logic [CFG_W-1:0]   r_short;
    logic [CFG_W-1:0]   r_long;
    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               advance;
    logic               proc;
    logic               in_accept;
    t_timer_cmd         timer_cmd;
    logic [IDX_W-1:0]   timer_idx;
    logic [TIMER_W-1:0] timer_val;
    t_out_item          result;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounce <= BOUNCE_RST;
            r_short  <= SHORT_RST;
            r_long   <= LONG_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BOUNCE: r_bounce <= i_cfg_data;
                CFG_SHORT:  r_short  <= i_cfg_data;
                CFG_LONG:   r_long   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline handshake
    assign advance    = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Per-switch machines
    bdpc_switch_ctl #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_switch_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_proc   (proc),
        .i_item   (r_in),
        .i_bounce (r_bounce),
        .i_short  (r_short),
        .i_long   (r_long),
        .i_timer  (timer_val),
        .o_cmd    (timer_cmd),
        .o_idx    (timer_idx),
        .o_result (result)
    );

    // Hold timers
    bdpc_timers #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_timers (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_long_limit (r_long),
        .i_cmd        (timer_cmd),
        .i_idx        (timer_idx),
        .o_timer      (timer_val)
    );

endmodule

[hdl/bdpc_timers.sv]
// ----------------------------------------------------------------------------
// bdpc_timers
// Per-switch hold timers: advance all on tick, clear one on request.
// ----------------------------------------------------------------------------
module bdpc_timers
    import bdpc_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF,
    localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CFG_W-1:0]   i_long_limit,
    input  t_timer_cmd         i_cmd,
    input  logic [IDX_W-1:0]   i_idx,
    output logic [TIMER_W-1:0] o_timer
);

    logic [TIMER_W-1:0] r_timer [NUM_SWITCHES];
    logic [TIMER_W-1:0] n_timer [NUM_SWITCHES];

    // Next timer values: saturate one past the long limit
    always_comb begin
        for (int i = 0; i < NUM_SWITCHES; i++) begin
            n_timer[i] = r_timer[i];
            if (i_cmd.clr && (i_idx == IDX_W'(i))) begin
                n_timer[i] = '0;
            end else if (i_cmd.tick && (r_timer[i] <= {1'b0, i_long_limit})) begin
                n_timer[i] = r_timer[i] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_SWITCHES; i++) begin
            if (!i_rst_n) begin
                r_timer[i] <= '0;
            end else begin
                r_timer[i] <= n_timer[i];
            end
        end
    end

    // Read the addressed switch's timer
    assign o_timer = r_timer[i_idx];

endmodule

[hdl/bdpc_switch_ctl.sv]
// ----------------------------------------------------------------------------
// bdpc_switch_ctl
// Per-switch press state machines and event codes; steps the addressed switch.
// ----------------------------------------------------------------------------
module bdpc_switch_ctl
    import bdpc_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF,
    localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_proc,
    input  t_in_item           i_item,
    input  logic [CFG_W-1:0]   i_bounce,
    input  logic [CFG_W-1:0]   i_short,
    input  logic [CFG_W-1:0]   i_long,
    input  logic [TIMER_W-1:0] i_timer,
    output t_timer_cmd         o_cmd,
    output logic [IDX_W-1:0]   o_idx,
    output t_out_item          o_result
);

    logic [ST_W-1:0] r_state [NUM_SWITCHES];
    logic [EV_W-1:0] r_event [NUM_SWITCHES];

    logic            sw_ok;
    logic [IDX_W-1:0] idx;
    logic [ST_W-1:0] cur_state;
    logic [EV_W-1:0] cur_event;
    logic [ST_W-1:0] n_state;
    logic [EV_W-1:0] n_event;
    logic            timer_clr;
    logic            do_eval;
    logic            do_clear;

    assign sw_ok     = (32'(i_item.sw_index) < NUM_SWITCHES);
    assign idx       = IDX_W'(i_item.sw_index);
    assign cur_state = r_state[idx];
    assign cur_event = r_event[idx];
    assign do_eval   = i_proc && sw_ok && (i_item.op == OP_EVAL);
    assign do_clear  = i_proc && sw_ok && (i_item.op == OP_CLEAR);

    // Step the addressed machine
    always_comb begin
        n_state   = cur_state;
        n_event   = cur_event;
        timer_clr = 1'b0;
        unique case (i_item.op)
            OP_EVAL: begin
                unique case (cur_state)
                    ST_PRESSED: begin
                        timer_clr = 1'b1;
                        n_state   = ST_BOUNCE;
                    end
                    ST_BOUNCE: begin
                        if (i_timer >= {1'b0, i_bounce}) begin
                            n_state = i_item.pressed ? ST_CONFIRMED : ST_IDLE;
                        end else if (!i_item.pressed) begin
                            n_state = ST_IDLE;
                        end
                    end
                    ST_CONFIRMED: begin
                        timer_clr = 1'b1;
                        n_state   = ST_WAIT_REL;
                        n_event   = EV_JUST_PRESSED;
                    end
                    ST_WAIT_REL: begin
                        if (!i_item.pressed) begin
                            n_event   = (i_timer < {1'b0, i_short}) ? EV_SHORT : EV_LONG;
                            timer_clr = 1'b1;
                            n_state   = ST_REL_BOUNCE;
                        end else if (i_timer > {1'b0, i_long}) begin
                            n_event = EV_LONG;
                            n_state = ST_WAIT_REL_LONG;
                        end
                    end
                    ST_WAIT_REL_LONG: begin
                        if (!i_item.pressed) begin
                            timer_clr = 1'b1;
                            n_state   = ST_REL_BOUNCE;
                        end
                    end
                    ST_REL_BOUNCE: begin
                        if (i_timer >= {1'b0, i_bounce}) begin
                            n_event = EV_JUST_RELEASED;
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        // idle, and any code that cannot arise
                        n_state = i_item.pressed ? ST_PRESSED : ST_IDLE;
                    end
                endcase
            end
            OP_CLEAR: n_event = EV_NONE;
            default: ;
        endcase
    end

    // Hold state and event arrays
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_SWITCHES; i++) begin
            if (!i_rst_n) begin
                r_state[i] <= ST_IDLE;
                r_event[i] <= EV_NONE;
            end else if ((do_eval || do_clear) && (idx == IDX_W'(i))) begin
                r_state[i] <= n_state;
                r_event[i] <= n_event;
            end
        end
    end

    // Drive timer bank
    assign o_cmd.tick = i_proc && (i_item.op == OP_TICK);
    assign o_cmd.clr  = do_eval && timer_clr;
    assign o_idx      = idx;

    // Report the addressed switch after the step
    assign o_result.event_code    = sw_ok ? n_event : EV_NONE;
    assign o_result.machine_state = sw_ok ? n_state : ST_IDLE;

endmodule

[sim/button_debounce_press_classifier_top_tb.sv]
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top_tb
// Self-checking bench for the button debounce and press classifier. A queue
// of words feeds a clocked driver. Directed words cover the field extremes,
// the unused operation, switches out of range and timer saturation. Random
// phases then hold each button level over many evaluate words, so presses
// run through bounce, short, long and release. Each phase uses its own
// register setting. A predictor inside the bench works out every result,
// and a clocked monitor checks the results in order. Both ports idle and
// stall at random.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top_tb;
    import bdpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSW         = NUM_SWITCHES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 115;

    // Operation and register index with no meaning in the block
    localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // Bench copy of the registers and the per-switch state
    logic [CFG_W-1:0]   bounce_lim = BOUNCE_RST;
    logic [CFG_W-1:0]   short_lim  = SHORT_RST;
    logic [CFG_W-1:0]   long_lim   = LONG_RST;
    logic [ST_W-1:0]    sw_state  [NSW] = '{default: ST_IDLE};
    logic [TIMER_W-1:0] hold_time [NSW] = '{default: '0};
    logic [EV_W-1:0]    ev_code   [NSW] = '{default: EV_NONE};

    // Held button level per switch index, the unused index too
    logic btn_level [8] = '{default: 1'b0};

    t_in_item  pending_words [$];
    t_out_item expected_results [$];

    int gap_left    = 0;
    int stall_left  = 0;
    bit steady_in   = 1'b0;
    bit steady_out  = 1'b0;
    int mismatches  = 0;
    int checked     = 0;
    int cycle_count = 0;

    button_debounce_press_classifier_top #(
        .NUM_SWITCHES(NSW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Advance the switch bank by one word and return the addressed switch
    function automatic t_out_item step_switches(t_in_item w);
        t_out_item   r;
        int unsigned s;
        logic        dn;
        s  = w.sw_index;
        dn = w.pressed;
        r  = '0;
        case (w.op)
            OP_TICK: begin
                for (int i = 0; i < NSW; i++)
                    if (hold_time[i] <= long_lim)
                        hold_time[i]++;
            end
            OP_EVAL: begin
                if (s < NSW) begin
                    case (sw_state[s])
                        ST_PRESSED: begin
                            hold_time[s] = '0;
                            sw_state[s]  = ST_BOUNCE;
                        end
                        ST_BOUNCE: begin
                            if (hold_time[s] >= bounce_lim)
                                sw_state[s] = dn ? ST_CONFIRMED : ST_IDLE;
                            else if (!dn)
                                sw_state[s] = ST_IDLE;
                        end
                        ST_CONFIRMED: begin
                            hold_time[s] = '0;
                            sw_state[s]  = ST_WAIT_REL;
                            ev_code[s]   = EV_JUST_PRESSED;
                        end
                        ST_WAIT_REL: begin
                            // Classify on release, then catch a hold past the long limit
                            if (!dn) begin
                                ev_code[s]   = (hold_time[s] < short_lim) ? EV_SHORT : EV_LONG;
                                hold_time[s] = '0;
                                sw_state[s]  = ST_REL_BOUNCE;
                            end
                            if (hold_time[s] > long_lim) begin
                                ev_code[s]  = EV_LONG;
                                sw_state[s] = ST_WAIT_REL_LONG;
                            end
                        end
                        ST_WAIT_REL_LONG: begin
                            if (!dn) begin
                                hold_time[s] = '0;
                                sw_state[s]  = ST_REL_BOUNCE;
                            end
                        end
                        ST_REL_BOUNCE: begin
                            if (hold_time[s] >= bounce_lim) begin
                                ev_code[s]  = EV_JUST_RELEASED;
                                sw_state[s] = ST_IDLE;
                            end
                        end
                        default: begin
                            sw_state[s] = dn ? ST_PRESSED : ST_IDLE;
                        end
                    endcase
                end
            end
            OP_CLEAR: begin
                if (s < NSW)
                    ev_code[s] = EV_NONE;
            end
            default: ;
        endcase
        if (s < NSW) begin
            r.event_code    = ev_code[s];
            r.machine_state = sw_state[s];
        end
        return r;
    endfunction

    function automatic t_in_item word(logic [OP_W-1:0] op, int sw, logic dn);
        t_in_item w;
        w.op       = op;
        w.sw_index = sw[SW_W-1:0];
        w.pressed  = dn;
        return w;
    endfunction

    // Draw a word: evaluates follow a held level with rare glitches
    function automatic t_in_item random_word();
        t_in_item w;
        int       roll;
        roll       = $urandom_range(0, 99);
        w.sw_index = ($urandom_range(0, 15) == 0) ? SW_W'(7) : SW_W'($urandom_range(0, NSW - 1));
        w.pressed  = 1'($urandom_range(0, 1));
        if (roll < 38) begin
            w.op = OP_TICK;
        end else if (roll < 86) begin
            w.op = OP_EVAL;
            if ($urandom_range(0, 6) == 0)
                btn_level[w.sw_index] = !btn_level[w.sw_index];
            w.pressed = btn_level[w.sw_index];
            if ($urandom_range(0, 19) == 0)
                w.pressed = !w.pressed;
        end else if (roll < 94) begin
            w.op = OP_CLEAR;
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d expected %0d", checked, field, got, want);
        mismatches++;
    endtask

    // Drive the input channel from the queue; predict each accepted word
    always @(posedge i_clk) begin : feed
        logic vld;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            vld = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(step_switches(i_in_item));
                vld = 1'b0;
            end
            if (!vld) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0) begin
                    i_in_item <= pending_words.pop_front();
                    vld = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        steady_in = !steady_in;
                    gap_left = steady_in ? 0 : $urandom_range(0, 14);
                end
            end
            i_in_valid <= vld;
        end
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge i_clk) begin : collect
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", o_out_item, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_item.event_code !== want.event_code)
                        report_mismatch("event_code", o_out_item.event_code, want.event_code);
                    if (o_out_item.machine_state !== want.machine_state)
                        report_mismatch("machine_state", o_out_item.machine_state,
                                        want.machine_state);
                end
                checked++;
                if ($urandom_range(0, 39) == 0)
                    steady_out = !steady_out;
                stall_left = steady_out ? 0 : $urandom_range(0, 14);
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Hold valid through a group of register writes; caller lowers it after
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BOUNCE: bounce_lim = val;
            CFG_SHORT:  short_lim  = val;
            CFG_LONG:   long_lim   = val;
            default: ;
        endcase
    endtask

    task automatic write_limits(input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] s,
                                input logic [CFG_W-1:0] l, input bit spare);
        if (spare)
            write_reg(CFG_SPARE, CFG_W'($urandom_range(0, 16383)));
        write_reg(CFG_BOUNCE, b);
        write_reg(CFG_SHORT, s);
        write_reg(CFG_LONG, l);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every word is through, then let the pipeline settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || expected_results.size() != 0 || i_in_valid);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] b, s, l;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limits: unused op, unused switch index, short bounce abort
        pending_words.push_back(word(OP_UNUSED, 7, 1'b1));
        pending_words.push_back(word(OP_EVAL, 7, 1'b1));
        pending_words.push_back(word(OP_CLEAR, 7, 1'b0));
        pending_words.push_back(word(OP_TICK, 7, 1'b0));
        pending_words.push_back(word(OP_EVAL, 0, 1'b1));
        pending_words.push_back(word(OP_EVAL, 0, 1'b1));
        pending_words.push_back(word(OP_TICK, 0, 1'b1));
        pending_words.push_back(word(OP_EVAL, 0, 1'b0));
        pending_words.push_back(word(OP_CLEAR, 0, 1'b1));
        pending_words.push_back(word(OP_UNUSED, 6, 1'b0));
        wait_idle();

        // Zero bounce, tiny limits: early long press, timer saturation, release
        write_limits(14'd0, 14'd2, 14'd3, 1'b1);
        repeat (4) pending_words.push_back(word(OP_EVAL, 1, 1'b1));
        repeat (5) pending_words.push_back(word(OP_TICK, 3, 1'b0));
        pending_words.push_back(word(OP_EVAL, 1, 1'b1));
        pending_words.push_back(word(OP_EVAL, 1, 1'b0));
        pending_words.push_back(word(OP_EVAL, 1, 1'b0));
        pending_words.push_back(word(OP_CLEAR, 1, 1'b0));
        wait_idle();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                4: begin
                    b = '1; s = '1; l = '1;
                end
                7: begin
                    b = '0; s = '0; l = '0;
                end
                10: begin
                    b = 14'd1; s = 14'd1; l = 14'd1;
                end
                default: begin
                    b = CFG_W'($urandom_range(0, 4));
                    s = CFG_W'($urandom_range(1, 12));
                    l = CFG_W'($urandom_range(2, 20));
                end
            endcase
            write_limits(b, s, l, ph % 4 == 0);
            repeat (PHASE_WORDS) pending_words.push_back(random_word());
            wait_idle();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/bdpc_pkg.sv
hdl/bdpc_timers.sv
hdl/bdpc_switch_ctl.sv
hdl/button_debounce_press_classifier_top.sv
sim/button_debounce_press_classifier_top_tb.sv
